// ===== sv/rfe_pkg.sv =====
// ----------------------------------------------------------------------------
// rfe_pkg
// Shared constants, codes, types and helper functions of the ribbon filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfe_pkg;

    localparam int RFE_BAND = 32;
    localparam int RFE_FP_BITS = 8;
    localparam int RFE_XS_SHIFT = 33;

    localparam logic [63:0] RFE_MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] RFE_MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] RFE_GOLDEN = 64'h9E3779B97F4A7C15;

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_SOLVE = 3'd2;
    localparam logic [2:0] ACT_QUERY = 3'd3;
    localparam logic [2:0] ACT_READ = 3'd4;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_CONFLICT = 2'd2;
    localparam logic [1:0] STAT_REFUSED = 2'd3;

    localparam logic CFG_SLOT_COUNT = 1'b0;
    localparam logic CFG_HASH_SEED = 1'b1;

    typedef struct packed {
        logic [31:0] row;
        logic [7:0]  fp;
    } t_hash_res;

    function automatic logic [63:0] xor_shift(input logic [63:0] x);
        return x ^ (x >> RFE_XS_SHIFT);
    endfunction

    function automatic logic [4:0] lowest_bit(input logic [31:0] v);
        logic [4:0] n;
        n = 5'd31;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) n = 5'(i);
        end
        return n;
    endfunction

    function automatic logic [4:0] highest_bit(input logic [31:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) n = 5'(i);
        end
        return n;
    endfunction

endpackage

// ===== sv/rfe_in_if.sv =====
// ----------------------------------------------------------------------------
// rfe_in_if
// Input item channel: action, key and slot with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rfe_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [63:0] key;
    logic [11:0] slot;

    modport source (output valid, action, key, slot, input ready);
    modport sink (input valid, action, key, slot, output ready);
endinterface

// ===== sv/rfe_out_if.sv =====
// ----------------------------------------------------------------------------
// rfe_out_if
// Result item channel: status, query answer and payload byte with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rfe_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       maybe_present;
    logic [7:0] payload_byte;

    modport source (output valid, status, maybe_present, payload_byte, input ready);
    modport sink (input valid, status, maybe_present, payload_byte, output ready);
endinterface

// ===== sv/ribbon_filter_engine_core.sv =====
// ----------------------------------------------------------------------------
// ribbon_filter_engine_core
// Banded GF(2) ribbon filter: build by elimination, back-solve, query.
// Hashing runs 4 finalizer rounds on one 32x32 multiplier, then a bit-serial
// remainder for the start slot; insert then walks the band in a pivot memory
// read loop, one slot per pass; query reads the solution bytes across the band;
// solve does one pivot read and one payload write per slot; read is one
// registered solution memory read; other codes are answered directly.
// Clear and reset run a clearing pass over the pivot memory; no item is taken
// until it ends. One item is in work at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ribbon_filter_engine_core #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rfe_in_if.sink       i_item,
    rfe_out_if.source    o_result,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int SW = SLOT_W + 1;
    localparam int CW = (SW > 13) ? SW : 13;
    localparam int PW = rfe_pkg::RFE_BAND + rfe_pkg::RFE_FP_BITS;

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_HASH    = 10'b0000000100,
        S_ELIM_A  = 10'b0000001000,
        S_ELIM_D  = 10'b0000010000,
        S_SOLVE_A = 10'b0000100000,
        S_SOLVE_D = 10'b0001000000,
        S_QUERY   = 10'b0010000000,
        S_READ    = 10'b0100000000,
        S_OUT     = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [12:0] r_slot_count;
    logic [15:0] r_hash_seed;
    logic [2:0]  r_act, n_act;
    logic        r_failed, n_failed;
    logic        r_solved, n_solved;
    logic        r_clr_reply, n_clr_reply;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_s, n_s;
    logic [31:0] r_c, n_c;
    logic [7:0]  r_f, n_f;
    logic [5:0]  r_qi, n_qi;
    logic [7:0]  r_qacc, n_qacc;
    logic        r_take, n_take;
    logic [1:0]  r_res_status, n_res_status;
    logic        r_res_maybe, n_res_maybe;
    logic [7:0]  r_res_byte, n_res_byte;
    logic        r_ov, n_ov;
    logic [1:0]  r_o_status;
    logic        r_o_maybe;
    logic [7:0]  r_o_byte;
    logic [7:0]  r_win [0:rfe_pkg::RFE_BAND-2];
    logic        w_win_clear;
    logic        w_win_shift;
    logic        w_load_out;

    logic [CW-1:0] w_sc;
    logic [CW-1:0] w_mc;
    logic [SW-1:0] w_m;
    logic [31:0]   w_slot32;
    logic          w_slot_ok;

    logic              w_hash_start;
    logic              w_hash_done;
    logic [SW-2:0]     w_hash_startslot;
    rfe_pkg::t_hash_res w_hash_res;

    logic              w_piv_we;
    logic [SLOT_W-1:0] w_piv_waddr;
    logic [PW-1:0]     w_piv_wdata;
    logic [SLOT_W-1:0] w_piv_raddr;
    logic [PW-1:0]     w_piv_rdata;
    logic [31:0]       w_piv_row;
    logic [7:0]        w_piv_rhs;

    logic              w_sol_we;
    logic [SLOT_W-1:0] w_sol_raddr;
    logic [7:0]        w_sol_rdata;
    logic [7:0]        w_acc;

    logic [4:0]    w_sh;
    logic [SW-1:0] w_s2;
    logic [SW-1:0] w_s_top;
    logic [SW-1:0] w_s_dec;
    logic [SW-1:0] w_qaddr;
    logic [7:0]    w_qacc;

    // slots in use, saturated into the legal range
    assign w_sc = CW'(r_slot_count);
    assign w_mc = (w_sc < CW'(rfe_pkg::RFE_BAND + 1)) ? CW'(rfe_pkg::RFE_BAND + 1) :
                  (w_sc > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : w_sc;
    assign w_m = w_mc[SW-1:0];

    assign w_slot32 = 32'(i_item.slot);
    assign w_slot_ok = w_slot32 < 32'(MAX_SLOTS);

    assign w_piv_row = w_piv_rdata[PW-1:rfe_pkg::RFE_FP_BITS];
    assign w_piv_rhs = w_piv_rdata[rfe_pkg::RFE_FP_BITS-1:0];

    assign w_sh = rfe_pkg::lowest_bit(r_c);
    assign w_s2 = r_s + SW'(w_sh);
    assign w_s_top = r_s + SW'(rfe_pkg::highest_bit(r_c));
    assign w_s_dec = r_s - SW'(1);
    assign w_qaddr = r_s + SW'(r_qi);
    assign w_qacc = r_qacc ^ (r_take ? w_sol_rdata : 8'd0);

    // back-substitution: window holds solution bytes of slots s+1..s+31
    always_comb begin
        w_acc = w_piv_rhs;
        for (int i = 1; i < rfe_pkg::RFE_BAND; i++) begin
            if (w_piv_row[i]) w_acc = w_acc ^ r_win[i-1];
        end
        if (w_piv_row == 32'd0) w_acc = 8'd0;
    end

    rfe_hash #(
        .SW(SW)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (i_item.key),
        .i_seed  (r_hash_seed),
        .i_m     (w_m),
        .o_done  (w_hash_done),
        .o_start (w_hash_startslot),
        .o_res   (w_hash_res)
    );

    rfe_ram #(
        .WIDTH(PW),
        .DEPTH(MAX_SLOTS)
    ) u_pivot_ram (
        .i_clk   (i_clk),
        .i_we    (w_piv_we),
        .i_waddr (w_piv_waddr),
        .i_wdata (w_piv_wdata),
        .i_raddr (w_piv_raddr),
        .o_rdata (w_piv_rdata)
    );

    rfe_ram #(
        .WIDTH(8),
        .DEPTH(MAX_SLOTS)
    ) u_sol_ram (
        .i_clk   (i_clk),
        .i_we    (w_sol_we),
        .i_waddr (r_s[SLOT_W-1:0]),
        .i_wdata (w_acc),
        .i_raddr (w_sol_raddr),
        .o_rdata (w_sol_rdata)
    );

    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_act = r_act;
        n_failed = r_failed;
        n_solved = r_solved;
        n_clr_reply = r_clr_reply;
        n_cnt = r_cnt;
        n_s = r_s;
        n_c = r_c;
        n_f = r_f;
        n_qi = r_qi;
        n_qacc = r_qacc;
        n_take = r_take;
        n_res_status = r_res_status;
        n_res_maybe = r_res_maybe;
        n_res_byte = r_res_byte;
        w_hash_start = 1'b0;
        w_piv_we = 1'b0;
        w_piv_waddr = r_s[SLOT_W-1:0];
        w_piv_wdata = {r_c, r_f};
        w_piv_raddr = r_s[SLOT_W-1:0];
        w_sol_we = 1'b0;
        w_sol_raddr = w_slot32[SLOT_W-1:0];
        w_win_clear = 1'b0;
        w_win_shift = 1'b0;
        w_load_out = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_piv_we = 1'b1;
                w_piv_waddr = r_cnt;
                w_piv_wdata = '0;
                n_cnt = r_cnt + SLOT_W'(1);
                if (r_cnt == SLOT_W'(MAX_SLOTS - 1)) begin
                    n_cnt = '0;
                    n_state = r_clr_reply ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item.valid) begin
                    n_act = i_item.action;
                    n_res_status = rfe_pkg::STAT_OK;
                    n_res_maybe = 1'b0;
                    n_res_byte = 8'd0;
                    n_state = S_OUT;
                    unique case (i_item.action)
                        rfe_pkg::ACT_CLEAR: begin
                            n_failed = 1'b0;
                            n_solved = 1'b0;
                            n_cnt = '0;
                            n_clr_reply = 1'b1;
                            n_state = S_CLEAR;
                        end
                        rfe_pkg::ACT_INSERT: begin
                            if (r_failed) begin
                                n_res_status = rfe_pkg::STAT_REFUSED;
                            end else begin
                                n_solved = 1'b0;
                                w_hash_start = 1'b1;
                                n_state = S_HASH;
                            end
                        end
                        rfe_pkg::ACT_SOLVE: begin
                            if (r_failed) begin
                                n_res_status = rfe_pkg::STAT_REFUSED;
                            end else begin
                                n_s = w_m;
                                w_win_clear = 1'b1;
                                n_state = S_SOLVE_A;
                            end
                        end
                        rfe_pkg::ACT_QUERY: begin
                            if (!r_solved) begin
                                n_res_status = rfe_pkg::STAT_REFUSED;
                                n_res_maybe = 1'b1;
                            end else begin
                                w_hash_start = 1'b1;
                                n_state = S_HASH;
                            end
                        end
                        rfe_pkg::ACT_READ: begin
                            if (w_slot_ok) n_state = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_s = SW'(w_hash_startslot);
                    n_c = w_hash_res.row;
                    n_f = w_hash_res.fp;
                    n_qi = 6'd0;
                    n_qacc = 8'd0;
                    n_take = 1'b0;
                    n_state = (r_act == rfe_pkg::ACT_INSERT) ? S_ELIM_A : S_QUERY;
                end
            end
            S_ELIM_A: begin
                if (r_c == 32'd0) begin
                    if (r_f != 8'd0) begin
                        n_res_status = rfe_pkg::STAT_CONFLICT;
                        n_failed = 1'b1;
                    end
                    n_state = S_OUT;
                end else if (w_s2 >= w_m) begin
                    n_res_status = rfe_pkg::STAT_OVERFLOW;
                    n_failed = 1'b1;
                    n_state = S_OUT;
                end else begin
                    w_piv_raddr = w_s2[SLOT_W-1:0];
                    n_s = w_s2;
                    n_c = r_c >> w_sh;
                    n_state = S_ELIM_D;
                end
            end
            S_ELIM_D: begin
                if (w_piv_row == 32'd0) begin
                    if (w_s_top >= w_m) begin
                        n_res_status = rfe_pkg::STAT_OVERFLOW;
                        n_failed = 1'b1;
                    end else begin
                        w_piv_we = 1'b1;
                    end
                    n_state = S_OUT;
                end else begin
                    n_c = (r_c ^ w_piv_row) >> 1;
                    n_f = r_f ^ w_piv_rhs;
                    n_s = r_s + SW'(1);
                    n_state = S_ELIM_A;
                end
            end
            S_SOLVE_A: begin
                if (r_s == '0) begin
                    n_solved = 1'b1;
                    n_state = S_OUT;
                end else begin
                    w_piv_raddr = w_s_dec[SLOT_W-1:0];
                    n_s = w_s_dec;
                    n_state = S_SOLVE_D;
                end
            end
            S_SOLVE_D: begin
                w_sol_we = 1'b1;
                w_win_shift = 1'b1;
                n_state = S_SOLVE_A;
            end
            S_QUERY: begin
                w_sol_raddr = w_qaddr[SLOT_W-1:0];
                if (r_qi != 6'd0) n_qacc = w_qacc;
                if (r_qi == 6'(rfe_pkg::RFE_BAND)) begin
                    n_res_maybe = (w_qacc == r_f);
                    n_state = S_OUT;
                end else begin
                    n_take = r_c[r_qi[4:0]];
                    n_qi = r_qi + 6'd1;
                end
            end
            S_READ: begin
                n_res_byte = w_sol_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || o_result.ready) begin
                    w_load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_ov = r_ov && !o_result.ready;
        if (w_load_out) n_ov = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_failed <= 1'b0;
            r_solved <= 1'b0;
            r_clr_reply <= 1'b0;
            r_cnt <= '0;
            r_ov <= 1'b0;
            r_slot_count <= 13'd4096;
            r_hash_seed <= 16'd0;
        end else begin
            r_state <= n_state;
            r_failed <= n_failed;
            r_solved <= n_solved;
            r_clr_reply <= n_clr_reply;
            r_cnt <= n_cnt;
            r_ov <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rfe_pkg::CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[12:0];
                    rfe_pkg::CFG_HASH_SEED: r_hash_seed <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;
        r_s <= n_s;
        r_c <= n_c;
        r_f <= n_f;
        r_qi <= n_qi;
        r_qacc <= n_qacc;
        r_take <= n_take;
        r_res_status <= n_res_status;
        r_res_maybe <= n_res_maybe;
        r_res_byte <= n_res_byte;
        if (w_load_out) begin
            r_o_status <= r_res_status;
            r_o_maybe <= r_res_maybe;
            r_o_byte <= r_res_byte;
        end
        if (w_win_clear) begin
            for (int i = 0; i < rfe_pkg::RFE_BAND - 1; i++) r_win[i] <= 8'd0;
        end else if (w_win_shift) begin
            r_win[0] <= w_acc;
            for (int i = 1; i < rfe_pkg::RFE_BAND - 1; i++) r_win[i] <= r_win[i-1];
        end
    end

    assign o_result.valid = r_ov;
    assign o_result.status = r_o_status;
    assign o_result.maybe_present = r_o_maybe;
    assign o_result.payload_byte = r_o_byte;

`ifndef SYNTHESIS
    // no item taken while the pivot memory is being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_item.ready)
        else $error("item accepted during clearing pass");

    // pivot memory only written by the clearing pass or a finished elimination
    a_piv_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_piv_we |-> (r_state == S_CLEAR || r_state == S_ELIM_D))
        else $error("unexpected pivot write");

    // an elimination read is always inside the slots in use
    a_elim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ELIM_D) |-> (r_s < w_m))
        else $error("elimination slot out of range");

    // an overflow or conflict result leaves the build marked failed
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && (r_res_status == rfe_pkg::STAT_OVERFLOW
                        || r_res_status == rfe_pkg::STAT_CONFLICT)) |=> r_failed)
        else $error("failure not recorded");
`endif

endmodule

// ===== sv/rfe_ram.sv =====
// ----------------------------------------------------------------------------
// rfe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rfe_hash.sv =====
// ----------------------------------------------------------------------------
// rfe_hash
// Seeded key hash: two 64-bit finalizers on one shared 32x32 multiplier,
// then a bit-serial remainder for the start slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfe_hash #(
    parameter int SW = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [63:0]         i_key,
    input  logic [15:0]         i_seed,
    input  logic [SW-1:0]       i_m,
    output logic                o_done,
    output logic [SW-2:0]       o_start,
    output rfe_pkg::t_hash_res  o_res
);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_MUL  = 3'b010,
        H_DIV  = 3'b100
    } t_hstate;

    t_hstate     r_state;
    logic [2:0]  r_step;
    logic [1:0]  r_idx;
    logic [4:0]  r_cnt;
    logic        r_done;
    logic [63:0] r_x;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [63:0] r_h1;
    logic [31:0] r_row;
    logic [31:0] r_q;
    logic [SW-1:0] r_rem;

    logic [63:0] w_const;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [63:0] w_xn;
    logic [SW-1:0] w_span;
    logic [SW:0] w_t;
    logic [SW:0] w_tsub;

    assign w_const = r_idx[0] ? rfe_pkg::RFE_MIX_C2 : rfe_pkg::RFE_MIX_C1;
    // low 64 bits of x*c from three partial products
    assign w_mul_a = (r_step == 3'd2) ? r_x[63:32] : r_x[31:0];
    assign w_mul_b = (r_step == 3'd1) ? w_const[63:32] : w_const[31:0];
    assign w_prod = w_mul_a * w_mul_b;
    assign w_xn = rfe_pkg::xor_shift(r_acc);

    assign w_span = i_m - SW'(rfe_pkg::RFE_BAND);
    assign w_t = {r_rem, r_q[31]};
    assign w_tsub = w_t - {1'b0, w_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done <= 1'b0;
            r_step <= 3'd0;
            r_idx <= 2'd0;
            r_cnt <= 5'd0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_x <= rfe_pkg::xor_shift(i_key ^ {48'd0, i_seed});
                        r_step <= 3'd0;
                        r_idx <= 2'd0;
                        r_state <= H_MUL;
                    end
                end
                H_MUL: begin
                    r_prod <= w_prod;
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_acc <= r_prod;
                        3'd2, 3'd3: r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                        3'd4: begin
                            r_step <= 3'd0;
                            r_idx <= r_idx + 2'd1;
                            if (r_idx == 2'd1) begin
                                r_h1 <= w_xn;
                                r_x <= rfe_pkg::xor_shift({w_xn[31:0], w_xn[63:32]}
                                                          ^ rfe_pkg::RFE_GOLDEN);
                            end else if (r_idx == 2'd3) begin
                                r_row <= w_xn[31:0] | 32'd1;
                                r_q <= r_h1[63:32];
                                r_rem <= '0;
                                r_cnt <= 5'd0;
                                r_state <= H_DIV;
                            end else begin
                                r_x <= w_xn;
                            end
                        end
                        default: ;
                    endcase
                end
                H_DIV: begin
                    // restoring remainder, one dividend bit per cycle
                    r_rem <= (w_t >= {1'b0, w_span}) ? w_tsub[SW-1:0] : w_t[SW-1:0];
                    r_q <= {r_q[30:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_done <= 1'b1;
                        r_state <= H_IDLE;
                    end
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_start = r_rem[SW-2:0];
    assign o_res.row = r_row;
    assign o_res.fp = r_h1[63:56];

endmodule
